// ----- rtl/cp_pkg.sv -----
// ----------------------------------------------------------------------------
// cp_pkg
// shared constants, types and elaboration-time tables for the cartesian to
// polar converter
// ----------------------------------------------------------------------------
package cp_pkg;

  localparam int CP_COORD_WIDTH   = 16;
  localparam int CP_ANGLE_WIDTH   = 16;
  localparam int CP_CORDIC_STAGES = 16;

  // guard fraction bits on the x/y datapath
  localparam int CP_GUARD = 16;
  // angle accumulator fraction bits, in turns
  localparam int CP_ZFRAC = 40;
  // angle accumulator width, signed
  localparam int CP_ZW    = CP_ZFRAC + 2;
  // 1/(2*pi) in q32
  localparam logic [63:0] CP_INV2PI_Q32 = 64'd683565276;

  // quadrant flags that travel with each item
  typedef struct packed {
    logic dx_neg;
    logic dx_zero;
    logic dy_neg;
    logic dy_zero;
  } cp_quad_t;

  // unsigned 64-bit quotient by shift and subtract, table building only
  function automatic logic [63:0] cp_udiv64(input logic [63:0] num,
                                            input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = 64'd0;
    rem = 65'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in q40 turns, from the arctangent series in q62 radians
  function automatic logic [63:0] cp_atan_q40(input int i);
    logic [63:0] rad;
    logic [63:0] term;
    int          k;
    int          e;
    if (i == 0) begin
      return 64'd1 << 37;
    end
    rad = 64'd0;
    k   = 0;
    e   = 62 - i;
    while (e >= 0) begin
      term = cp_udiv64(64'd1 << e, 64'(2 * k + 1));
      if (k[0]) begin
        rad = rad - term;
      end else begin
        rad = rad + term;
      end
      k = k + 1;
      e = 62 - i * (2 * k + 1);
    end
    return ((rad >> 30) * CP_INV2PI_Q32) >> 24;
  endfunction

  // inverse cordic gain in q31, sqrt of prod 1/(1+4^-i) taken in q62
  function automatic logic [31:0] cp_inv_gain_q31(input int stages);
    logic [63:0] p;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    p = 64'd1 << 62;
    for (int i = 0; i < stages; i++) begin
      p = p - cp_udiv64(p, (64'd1 << (2 * i)) + 64'd1);
    end
    n = p;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > n) begin
      b = b >> 2;
    end
    while (b != 64'd0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

endpackage

// ----- rtl/cp_pre.sv -----
// ----------------------------------------------------------------------------
// cp_pre
// offset about the centre, fold into the first quadrant, load the cordic
// ----------------------------------------------------------------------------
module cp_pre
  import cp_pkg::*;
#(
  parameter int COORD_WIDTH = CP_COORD_WIDTH,
  parameter int DW          = CP_COORD_WIDTH + CP_GUARD + 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] center_x_i,
  input  logic signed [COORD_WIDTH-1:0] center_y_i,
  output logic                          valid_o,
  output logic signed [DW-1:0]          x_o,
  output logic signed [DW-1:0]          y_o,
  output cp_quad_t                      quad_o
);

  logic signed [COORD_WIDTH:0] dx;
  logic signed [COORD_WIDTH:0] dy;
  logic        [COORD_WIDTH:0] adx;
  logic        [COORD_WIDTH:0] ady;
  cp_quad_t                    quad_nxt;

  logic                        valid_r;
  logic signed [DW-1:0]        x_r;
  logic signed [DW-1:0]        y_r;
  cp_quad_t                    quad_r;

  always_comb begin
    dx  = (COORD_WIDTH+1)'(point_x_i) - (COORD_WIDTH+1)'(center_x_i);
    dy  = (COORD_WIDTH+1)'(point_y_i) - (COORD_WIDTH+1)'(center_y_i);
    // magnitude fits unsigned even for the most negative offset
    adx = dx[COORD_WIDTH] ? (~dx + 1'b1) : dx;
    ady = dy[COORD_WIDTH] ? (~dy + 1'b1) : dy;
    quad_nxt.dx_neg  = dx[COORD_WIDTH];
    quad_nxt.dx_zero = (dx == '0);
    quad_nxt.dy_neg  = dy[COORD_WIDTH];
    quad_nxt.dy_zero = (dy == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= $signed({{(DW-COORD_WIDTH-1-CP_GUARD){1'b0}}, adx, {CP_GUARD{1'b0}}});
      y_r    <= $signed({{(DW-COORD_WIDTH-1-CP_GUARD){1'b0}}, ady, {CP_GUARD{1'b0}}});
      quad_r <= quad_nxt;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign quad_o  = quad_r;

endmodule

// ----- rtl/cp_stage.sv -----
// ----------------------------------------------------------------------------
// cp_stage
// one vectoring micro-rotation of the cordic, registered
// ----------------------------------------------------------------------------
module cp_stage
  import cp_pkg::*;
#(
  parameter int DW    = CP_COORD_WIDTH + CP_GUARD + 4,
  parameter int STAGE = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   valid_i,
  input  logic signed [DW-1:0]   x_i,
  input  logic signed [DW-1:0]   y_i,
  input  logic signed [CP_ZW-1:0] z_i,
  input  cp_quad_t               quad_i,
  output logic                   valid_o,
  output logic signed [DW-1:0]   x_o,
  output logic signed [DW-1:0]   y_o,
  output logic signed [CP_ZW-1:0] z_o,
  output cp_quad_t               quad_o
);

  localparam logic [63:0]            ATAN64 = cp_atan_q40(STAGE);
  localparam logic signed [CP_ZW-1:0] ATAN  = $signed(ATAN64[CP_ZW-1:0]);

  logic signed [DW-1:0]    xs;
  logic signed [DW-1:0]    ys;
  logic signed [DW-1:0]    x_nxt;
  logic signed [DW-1:0]    y_nxt;
  logic signed [CP_ZW-1:0] z_nxt;

  logic                    valid_r;
  logic signed [DW-1:0]    x_r;
  logic signed [DW-1:0]    y_r;
  logic signed [CP_ZW-1:0] z_r;
  cp_quad_t                quad_r;

  always_comb begin
    // arithmetic shift floors toward minus infinity
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!y_i[DW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      quad_r <= quad_i;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign quad_o  = quad_r;

endmodule

// ----- rtl/cp_post.sv -----
// ----------------------------------------------------------------------------
// cp_post
// angle placement by quadrant and radius gain correction, two stages
// ----------------------------------------------------------------------------
module cp_post
  import cp_pkg::*;
#(
  parameter int COORD_WIDTH  = CP_COORD_WIDTH,
  parameter int ANGLE_WIDTH  = CP_ANGLE_WIDTH,
  parameter int CORDIC_STAGES = CP_CORDIC_STAGES,
  parameter int DW           = CP_COORD_WIDTH + CP_GUARD + 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_i,
  input  logic signed [DW-1:0]    x_i,
  input  logic signed [CP_ZW-1:0] z_i,
  input  cp_quad_t                quad_i,
  output logic                    valid_o,
  output logic [ANGLE_WIDTH-1:0]  angle_o,
  output logic [COORD_WIDTH:0]    radius_o
);

  localparam logic [31:0] INV_GAIN = cp_inv_gain_q31(CORDIC_STAGES);
  localparam int XPAD = (DW > 32) ? DW : 33;
  localparam int HW   = XPAD - 32;
  localparam int SW   = HW + 33;
  localparam int RSH  = CP_GUARD - 1;
  localparam int TSH  = CP_ZFRAC - ANGLE_WIDTH;
  localparam logic [CP_ZFRAC-2:0] ZQUARTER = {1'b1, {(CP_ZFRAC-2){1'b0}}};
  localparam logic [CP_ZFRAC-2:0] ZROUND   = (CP_ZFRAC-1)'(1) << (TSH - 1);
  localparam logic [ANGLE_WIDTH-1:0] QUARTER = {2'b01, {(ANGLE_WIDTH-2){1'b0}}};
  localparam logic [ANGLE_WIDTH-1:0] HALF    = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
  localparam logic [ANGLE_WIDTH-1:0] THREE_Q = {2'b11, {(ANGLE_WIDTH-2){1'b0}}};
  localparam logic [SW-1:0] RROUND = SW'(1) << (CP_GUARD + 31 - 33);

  logic [CP_ZFRAC-2:0]    zc;
  logic [CP_ZFRAC-2:0]    zsum;
  logic [ANGLE_WIDTH-1:0] t;
  logic [ANGLE_WIDTH-1:0] angle_nxt;
  logic [XPAD-1:0]        xe;
  logic [63:0]            lo_nxt;
  logic [HW+31:0]         hi_nxt;
  logic [SW-1:0]          rsum;

  logic                   a_valid_r;
  logic [ANGLE_WIDTH-1:0] a_angle_r;
  logic [63:0]            a_lo_r;
  logic [HW+31:0]         a_hi_r;

  logic                   b_valid_r;
  logic [ANGLE_WIDTH-1:0] b_angle_r;
  logic [COORD_WIDTH:0]   b_radius_r;

  // stage a: clamp and round the folded angle, split product of the radius
  always_comb begin
    if (quad_i.dy_zero || z_i[CP_ZW-1]) begin
      zc = '0;
    end else if (z_i > $signed({{(CP_ZW-CP_ZFRAC+1){1'b0}}, ZQUARTER})) begin
      zc = ZQUARTER;
    end else begin
      zc = z_i[CP_ZFRAC-2:0];
    end
    zsum = zc + ZROUND;
    t    = ANGLE_WIDTH'(zsum[CP_ZFRAC-2:TSH]);

    if (quad_i.dx_zero) begin
      angle_nxt = quad_i.dy_neg ? THREE_Q : QUARTER;
    end else if (!quad_i.dx_neg && !quad_i.dy_neg) begin
      angle_nxt = t;
    end else if (quad_i.dx_neg && !quad_i.dy_neg) begin
      angle_nxt = HALF - t;
    end else if (quad_i.dx_neg) begin
      angle_nxt = HALF + t;
    end else begin
      // full turn minus t, wraps to zero when t is zero
      angle_nxt = '0 - t;
    end

    xe     = XPAD'($unsigned(x_i));
    lo_nxt = xe[31:0] * INV_GAIN;
    hi_nxt = xe[XPAD-1:32] * INV_GAIN;
  end

  // stage b: recombine the partial products and round
  always_comb begin
    rsum = SW'(a_hi_r) + SW'(a_lo_r[63:32]) + RROUND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= valid_i;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_angle_r  <= angle_nxt;
      a_lo_r     <= lo_nxt;
      a_hi_r     <= hi_nxt;
      b_angle_r  <= a_angle_r;
      b_radius_r <= rsum[RSH +: COORD_WIDTH+1];
    end
  end

  assign valid_o  = b_valid_r;
  assign angle_o  = b_angle_r;
  assign radius_o = b_radius_r;

endmodule

// ----- rtl/cartesian_to_polar_top.sv -----
// ----------------------------------------------------------------------------
// cartesian_to_polar_top: point about a centre to angle and radius
// path from accept to out_valid: cp_pre register, a register per cordic stage, post stages a and b, output register
// throughput: one item per cycle while the skid stage is empty; each cordic iteration is its own stage
// reset: synchronous active-low rst_n clears every valid bit, no clearing pass
// ----------------------------------------------------------------------------
module cartesian_to_polar_top
  import cp_pkg::*;
#(
  parameter int COORD_WIDTH   = CP_COORD_WIDTH,
  parameter int ANGLE_WIDTH   = CP_ANGLE_WIDTH,
  parameter int CORDIC_STAGES = CP_CORDIC_STAGES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input item channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  // result item channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ANGLE_WIDTH-1:0]        out_angle,
  output logic [COORD_WIDTH:0]          out_radius
);

  // datapath width: offset magnitude, guard bits and cordic growth
  localparam int DW = COORD_WIDTH + CP_GUARD + 4;

  // whole pipeline advances together; it only halts when the skid stage
  // already holds an item, so in_stall comes straight from a flop
  logic adv;

  // per-stage signals, index 0 is the loaded cordic input
  logic                    v_s    [CORDIC_STAGES+1];
  logic signed [DW-1:0]    x_s    [CORDIC_STAGES+1];
  logic signed [DW-1:0]    y_s    [CORDIC_STAGES+1];
  logic signed [CP_ZW-1:0] z_s    [CORDIC_STAGES+1];
  cp_quad_t                quad_s [CORDIC_STAGES+1];

  // pipeline tail
  logic                   p_valid;
  logic [ANGLE_WIDTH-1:0] p_angle;
  logic [COORD_WIDTH:0]   p_radius;
  logic                   deliver;

  // output register and skid stage
  logic                   out_valid_r;
  logic [ANGLE_WIDTH-1:0] out_angle_r;
  logic [COORD_WIDTH:0]   out_radius_r;
  logic                   skid_valid_r;
  logic [ANGLE_WIDTH-1:0] skid_angle_r;
  logic [COORD_WIDTH:0]   skid_radius_r;
  logic                   out_free;

  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // offset, fold and load
  cp_pre #(
    .COORD_WIDTH (COORD_WIDTH),
    .DW          (DW)
  ) u_pre (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .valid_i    (in_valid),
    .point_x_i  (in_point_x),
    .point_y_i  (in_point_y),
    .center_x_i (in_center_x),
    .center_y_i (in_center_y),
    .valid_o    (v_s[0]),
    .x_o        (x_s[0]),
    .y_o        (y_s[0]),
    .quad_o     (quad_s[0])
  );

  // angle accumulator starts at zero for every item
  assign z_s[0] = '0;

  // one registered micro-rotation per stage
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    cp_stage #(
      .DW    (DW),
      .STAGE (g)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (v_s[g]),
      .x_i     (x_s[g]),
      .y_i     (y_s[g]),
      .z_i     (z_s[g]),
      .quad_i  (quad_s[g]),
      .valid_o (v_s[g+1]),
      .x_o     (x_s[g+1]),
      .y_o     (y_s[g+1]),
      .z_o     (z_s[g+1]),
      .quad_o  (quad_s[g+1])
    );
  end

  // quadrant placement and radius scaling
  cp_post #(
    .COORD_WIDTH   (COORD_WIDTH),
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES),
    .DW            (DW)
  ) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .valid_i  (v_s[CORDIC_STAGES]),
    .x_i      (x_s[CORDIC_STAGES]),
    .z_i      (z_s[CORDIC_STAGES]),
    .quad_i   (quad_s[CORDIC_STAGES]),
    .valid_o  (p_valid),
    .angle_o  (p_angle),
    .radius_o (p_radius)
  );

  // an item leaves the pipeline only on a cycle where it advances
  assign deliver  = adv && p_valid;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        // skid drains first; the pipeline is halted while it is full
        out_valid_r  <= skid_valid_r || deliver;
        skid_valid_r <= 1'b0;
      end else if (deliver) begin
        // output held by the receiver, park the item in the skid stage
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_angle_r  <= skid_angle_r;
        out_radius_r <= skid_radius_r;
      end else begin
        out_angle_r  <= p_angle;
        out_radius_r <= p_radius;
      end
    end else if (deliver) begin
      skid_angle_r  <= p_angle;
      skid_radius_r <= p_radius;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_angle  = out_angle_r;
  assign out_radius = out_radius_r;

endmodule
